// ===== hw/rtl/gdcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gdcr_pkg
// Shared types, constants and helpers for the column raycaster.
// ----------------------------------------------------------------------------
package gdcr_pkg;

	localparam int MAP_SIDE_DEF       = 8;
	localparam int SCREEN_COLUMNS_DEF = 384;
	localparam int SCREEN_ROWS_DEF    = 216;

	localparam int NUM_REGS = 6;

	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	localparam logic OP_CAST  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [15:0] RST_POS_X   = 16'd8192;
	localparam logic [15:0] RST_POS_Y   = 16'd8192;
	localparam logic [15:0] RST_DIR_X   = 16'hC052;
	localparam logic [15:0] RST_DIR_Y   = 16'd1630;
	localparam logic [15:0] RST_PLANE_X = 16'd0;
	localparam logic [15:0] RST_PLANE_Y = 16'd10813;

	localparam logic [31:0] COLOR_NONE  = 32'hFF000000;
	localparam logic [31:0] COLOR_RED   = 32'hFF0000FF;
	localparam logic [31:0] COLOR_GREEN = 32'hFF00FF00;
	localparam logic [31:0] COLOR_BLUE  = 32'hFFFF0000;
	localparam logic [31:0] COLOR_PINK  = 32'hFFFF00FF;
	localparam logic [7:0]  SHADE       = 8'hC0;

	typedef struct packed {
		logic       operation;
		logic [8:0] column;
		logic [5:0] cell_index;
		logic [2:0] cell_code;
	} in_item_t;

	typedef struct packed {
		logic [8:0]  out_column;
		logic [7:0]  wall_top;
		logic [7:0]  wall_bottom;
		logic [31:0] wall_color;
		logic        hit_y_side;
		logic [15:0] perp_distance;
		logic        out_of_bounds;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAY,
		ST_CHECK,
		ST_DIVX,
		ST_DIVY,
		ST_SIDE,
		ST_WALK,
		ST_READ,
		ST_HDIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic ray;
		logic div_start;
		logic div_sel_y;
		logic div_height;
		logic cap_dx;
		logic cap_dy;
		logic side;
		logic walk;
		logic read;
		logic emit;
	} ctrl_t;

	typedef struct packed {
		logic bad_start;
		logic div_done;
		logic walk_stop;
		logic hit;
	} stat_t;

	function automatic logic [31:0] wall_rgb(input logic [2:0] code);
		logic [31:0] c;
		unique case (code)
			3'd1:    c = COLOR_RED;
			3'd2:    c = COLOR_GREEN;
			3'd3:    c = COLOR_BLUE;
			3'd4:    c = COLOR_PINK;
			default: c = COLOR_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] shade_rgb(input logic [31:0] c);
		logic [15:0] r, g, b;
		r = c[7:0] * SHADE;
		g = c[15:8] * SHADE;
		b = c[23:16] * SHADE;
		return {8'hFF, b[15:8], g[15:8], r[15:8]};
	endfunction

endpackage

// ===== hw/rtl/gdcr_div.sv =====
// ----------------------------------------------------------------------------
// gdcr_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdcr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [44:0] dividend,
	input  logic [44:0] divisor,
	output logic        done,
	output logic [44:0] quotient
);

	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [44:0] rem_q;
	logic [44:0] quo_q;
	logic [44:0] dvs_q;
	logic [45:0] trial;

	assign trial = {rem_q, quo_q[44]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= 6'd45;
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				run_q <= 1'b0;
		end
	end

	// quotient is complete the cycle after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= !start && run_q && (cnt_q == 6'd1);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[45]) begin
				rem_q <= trial[44:0];
				quo_q <= {quo_q[43:0], 1'b1};
			end else begin
				rem_q <= {rem_q[43:0], quo_q[44]};
				quo_q <= {quo_q[43:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/gdcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdcr_ctrl
// Sequencer for one cast: ray set-up, reciprocals, walk, height, result.
// ----------------------------------------------------------------------------
module gdcr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  gdcr_pkg::stat_t stat,
	output gdcr_pkg::ctrl_t ctrl,
	output logic            busy
);

	gdcr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gdcr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gdcr_pkg::ST_IDLE:  if (go) state_d = gdcr_pkg::ST_RAY;
			gdcr_pkg::ST_RAY:   state_d = gdcr_pkg::ST_CHECK;
			gdcr_pkg::ST_CHECK: state_d = stat.bad_start ? gdcr_pkg::ST_DONE
				: gdcr_pkg::ST_DIVX;
			gdcr_pkg::ST_DIVX:  if (stat.div_done) state_d = gdcr_pkg::ST_DIVY;
			gdcr_pkg::ST_DIVY:  if (stat.div_done) state_d = gdcr_pkg::ST_SIDE;
			gdcr_pkg::ST_SIDE:  state_d = gdcr_pkg::ST_WALK;
			gdcr_pkg::ST_WALK:  state_d = stat.walk_stop ? gdcr_pkg::ST_DONE
				: gdcr_pkg::ST_READ;
			gdcr_pkg::ST_READ:  state_d = stat.hit ? gdcr_pkg::ST_HDIV
				: gdcr_pkg::ST_WALK;
			gdcr_pkg::ST_HDIV:  if (stat.div_done) state_d = gdcr_pkg::ST_DONE;
			gdcr_pkg::ST_DONE:  state_d = gdcr_pkg::ST_IDLE;
			default:            state_d = gdcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		busy = (state_q != gdcr_pkg::ST_IDLE);
		unique case (state_q)
			gdcr_pkg::ST_IDLE:  ctrl.load = go;
			gdcr_pkg::ST_RAY:   ctrl.ray = 1'b1;
			gdcr_pkg::ST_CHECK: ctrl.div_start = !stat.bad_start;
			gdcr_pkg::ST_DIVX:  begin
				ctrl.cap_dx = stat.div_done;
				ctrl.div_start = stat.div_done;
				ctrl.div_sel_y = stat.div_done;
			end
			gdcr_pkg::ST_DIVY:  begin
				ctrl.div_sel_y = 1'b1;
				ctrl.cap_dy = stat.div_done;
			end
			gdcr_pkg::ST_SIDE:  ctrl.side = 1'b1;
			gdcr_pkg::ST_WALK:  ctrl.walk = 1'b1;
			gdcr_pkg::ST_READ:  begin
				ctrl.read = 1'b1;
				ctrl.div_start = stat.hit;
				ctrl.div_height = stat.hit;
			end
			gdcr_pkg::ST_HDIV:  ctrl.div_height = 1'b1;
			gdcr_pkg::ST_DONE:  ctrl.emit = 1'b1;
			default:            ctrl = '0;
		endcase
	end

endmodule

// ===== hw/rtl/gdcr_dpath.sv =====
// ----------------------------------------------------------------------------
// gdcr_dpath
// Ray set-up, DDA walk registers, tile map and result formatting.
// ----------------------------------------------------------------------------
module gdcr_dpath #(
	parameter int MAP_SIDE       = gdcr_pkg::MAP_SIDE_DEF,
	parameter int SCREEN_COLUMNS = gdcr_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = gdcr_pkg::SCREEN_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gdcr_pkg::in_item_t  item,
	input  logic                item_write,
	input  logic [15:0]         pos_x,
	input  logic [15:0]         pos_y,
	input  logic signed [15:0]  dir_x,
	input  logic signed [15:0]  dir_y,
	input  logic signed [15:0]  pln_x,
	input  logic signed [15:0]  pln_y,
	input  gdcr_pkg::ctrl_t     ctrl,
	output gdcr_pkg::stat_t     stat,
	output logic                res_valid,
	output gdcr_pkg::out_item_t res
);

	localparam int CELLS  = MAP_SIDE * MAP_SIDE;
	// rounded up so that exact multiples floor correctly
	localparam longint RECIP = ((64'd1 << 31) + longint'(SCREEN_COLUMNS) - 1)
		/ longint'(SCREEN_COLUMNS);
	localparam int STEPS  = 2 * MAP_SIDE + 2;
	localparam int HALF   = SCREEN_ROWS / 2;

	// tile map: valid bit per cell, data held in a plain array
	logic [2:0]       map_q [CELLS];
	logic [CELLS-1:0] mval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mval_q <= '0;
		else if (item_write && (32'(item.cell_index) < CELLS))
			mval_q[item.cell_index] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (item_write && (32'(item.cell_index) < CELLS))
			map_q[item.cell_index] <= item.cell_code;
	end

	logic [8:0]          col_q;
	logic signed [15:0]  xcam_q;
	logic signed [32:0]  rx_q, ry_q;
	logic signed [6:0]   cx_q, cy_q;
	logic [31:0]         dx_q, dy_q;
	logic [47:0]         sx_q, sy_q, prev_q;
	logic                ux_q, uy_q, yside_q, oob_q, hit_q;
	logic [5:0]          n_q;
	logic [2:0]          code_q;
	logic [15:0]         d8_q;

	logic [40:0] xprod;
	assign xprod = 41'(item.column) * 41'(RECIP);

	logic signed [32:0] rx_d, ry_d;
	assign rx_d = 33'(dir_x) * 33'sd16384 + 33'(pln_x) * 33'(xcam_q);
	assign ry_d = 33'(dir_y) * 33'sd16384 + 33'(pln_y) * 33'(xcam_q);

	logic [32:0] mag_x, mag_y;
	assign mag_x = rx_q[32] ? 33'(-rx_q) : 33'(rx_q);
	assign mag_y = ry_q[32] ? 33'(-ry_q) : 33'(ry_q);

	logic [3:0] cx0, cy0;
	assign cx0 = pos_x[15:12];
	assign cy0 = pos_y[15:12];

	logic [15:0] d8_w;
	assign d8_w = (prev_q[47:36] != '0) ? 16'hFFFF : prev_q[35:20];

	logic        div_start;
	logic [44:0] div_a, div_b, div_q;
	logic        div_done;

	always_comb begin
		if (ctrl.div_height) begin
			div_a = 45'(SCREEN_ROWS) << 8;
			div_b = 45'(d8_w);
		end else begin
			div_a = 45'd1 << 44;
			div_b = ctrl.div_sel_y ? 45'(mag_y) : 45'(mag_x);
		end
	end
	assign div_start = ctrl.div_start &&
		!(ctrl.div_height && d8_w == 16'd0);

	gdcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	logic [31:0] div_sat;
	assign div_sat = (div_q[44:32] != '0) ? 32'hFFFFFFFF : div_q[31:0];

	// one DDA step
	logic        take_x;
	logic signed [6:0] ncx, ncy;
	logic        outside;
	assign take_x = ux_q && (!uy_q || sx_q < sy_q);
	assign ncx = take_x ? cx_q + (rx_q[32] ? -7'sd1 : 7'sd1) : cx_q;
	assign ncy = take_x ? cy_q : cy_q + (ry_q[32] ? -7'sd1 : 7'sd1);
	assign outside = ncx < 0 || ncx >= 7'(MAP_SIDE) || ncy < 0
		|| ncy >= 7'(MAP_SIDE);

	// map read for the cell being entered, registered at the walk step
	logic [15:0] nidx;
	logic [2:0]  rd_q;
	logic        rdv_q;
	logic [2:0]  rd_code;
	assign nidx = 16'(ncy) * 16'(MAP_SIDE) + 16'(ncx);

	always_ff @(posedge clk) begin
		if (ctrl.walk) begin
			rd_q  <= map_q[nidx[$clog2(CELLS)-1:0]];
			rdv_q <= mval_q[nidx[$clog2(CELLS)-1:0]];
		end
	end

	assign rd_code = rdv_q ? rd_q : 3'd0;

	assign stat.bad_start = (rx_q == 0 && ry_q == 0) || 32'(cx0) >= MAP_SIDE
		|| 32'(cy0) >= MAP_SIDE;
	assign stat.div_done  = div_done || (ctrl.div_height && d8_w == 16'd0
		&& !div_start);
	assign stat.walk_stop = outside || (32'(n_q) >= STEPS);
	assign stat.hit       = rd_code != 3'd0;

	logic [12:0] fx, fy;
	assign fx = rx_q[32] ? 13'(pos_x[11:0]) : 13'd4096 - 13'(pos_x[11:0]);
	assign fy = ry_q[32] ? 13'(pos_y[11:0]) : 13'd4096 - 13'(pos_y[11:0]);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			col_q  <= item.column;
			xcam_q <= 16'(xprod[40:16]) - 16'sd16384;
			oob_q  <= 1'b1;
			hit_q  <= 1'b0;
			code_q <= 3'd0;
			yside_q <= 1'b0;
			prev_q <= '0;
			d8_q   <= '0;
		end
		if (ctrl.ray) begin
			rx_q <= rx_d;
			ry_q <= ry_d;
			cx_q <= 7'(cx0);
			cy_q <= 7'(cy0);
			ux_q <= rx_d != 0;
			uy_q <= ry_d != 0;
			n_q  <= '0;
		end
		if (div_done && ctrl.cap_dx)
			dx_q <= div_sat;
		if (div_done && ctrl.cap_dy)
			dy_q <= div_sat;
		if (ctrl.side) begin
			sx_q <= 48'(dx_q) * 48'(fx);
			sy_q <= 48'(dy_q) * 48'(fy);
		end
		if (ctrl.walk) begin
			if (take_x) begin
				prev_q <= sx_q;
				sx_q <= sx_q + (48'(dx_q) << 12);
				yside_q <= 1'b0;
			end else begin
				prev_q <= sy_q;
				sy_q <= sy_q + (48'(dy_q) << 12);
				yside_q <= 1'b1;
			end
			cx_q <= ncx;
			cy_q <= ncy;
			n_q  <= n_q + 6'd1;
		end
		if (ctrl.read && stat.hit) begin
			hit_q  <= 1'b1;
			oob_q  <= 1'b0;
			code_q <= rd_code;
			d8_q   <= d8_w;
		end
	end

	// span
	logic [44:0] hgt, thalf;
	logic [44:0] top_w, bot_w;
	assign hgt   = div_q;
	assign thalf = hgt >> 1;
	assign top_w = (thalf >= 45'(HALF)) ? 45'd0 : 45'(HALF) - thalf;
	assign bot_w = (45'(HALF) + thalf > 45'(SCREEN_ROWS - 1))
		? 45'(SCREEN_ROWS - 1) : 45'(HALF) + thalf;

	logic [31:0] base_c;
	assign base_c = gdcr_pkg::wall_rgb(code_q);

	logic             rv_q;
	gdcr_pkg::out_item_t r_q, r_d;

	always_comb begin
		r_d = '0;
		r_d.out_column = col_q;
		r_d.out_of_bounds = !hit_q;
		if (hit_q) begin
			r_d.wall_color    = yside_q ? gdcr_pkg::shade_rgb(base_c) : base_c;
			r_d.hit_y_side    = yside_q;
			r_d.perp_distance = d8_q;
			r_d.wall_top      = (d8_q == 0) ? 8'd0 : top_w[7:0];
			r_d.wall_bottom   = (d8_q == 0) ? 8'(SCREEN_ROWS - 1) : bot_w[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rv_q <= 1'b0;
		else
			rv_q <= ctrl.emit;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit)
			r_q <= r_d;
	end

	assign res_valid = rv_q;
	assign res = r_q;

endmodule

// ===== hw/rtl/grid_dda_column_raycaster_unit.sv =====
// A write does not make the unit busy; a cast that hits shows its result after the transfer,
// once three serial 45-bit divisions have run: the two reciprocals and the height.
// Zero distance skips the height division; misses never start it.
// Throughput: one item at a time; busy falls in the cycle of the result strobe.
// Reset: registers return to the camera defaults, the tile map reads all zero.
// The result is shown for one cycle on result_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster_unit
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster_unit #(
	parameter int MAP_SIDE       = gdcr_pkg::MAP_SIDE_DEF,
	parameter int SCREEN_COLUMNS = gdcr_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = gdcr_pkg::SCREEN_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gdcr_pkg::in_item_t  item,
	output logic                result_valid,
	output gdcr_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	logic [15:0] reg_q [gdcr_pkg::NUM_REGS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q[gdcr_pkg::REG_POS_X]   <= gdcr_pkg::RST_POS_X;
			reg_q[gdcr_pkg::REG_POS_Y]   <= gdcr_pkg::RST_POS_Y;
			reg_q[gdcr_pkg::REG_DIR_X]   <= gdcr_pkg::RST_DIR_X;
			reg_q[gdcr_pkg::REG_DIR_Y]   <= gdcr_pkg::RST_DIR_Y;
			reg_q[gdcr_pkg::REG_PLANE_X] <= gdcr_pkg::RST_PLANE_X;
			reg_q[gdcr_pkg::REG_PLANE_Y] <= gdcr_pkg::RST_PLANE_Y;
		end else if (cfg_valid && cfg_ready && 32'(cfg_index) < gdcr_pkg::NUM_REGS) begin
			reg_q[cfg_index] <= cfg_data;
		end
	end

	logic accept, go, wr;
	assign accept = start && !busy;
	assign go = accept && item.operation == gdcr_pkg::OP_CAST;
	assign wr = accept && item.operation == gdcr_pkg::OP_WRITE;

	gdcr_pkg::ctrl_t ctrl;
	gdcr_pkg::stat_t stat;

	gdcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	gdcr_dpath #(
		.MAP_SIDE       (MAP_SIDE),
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_write (wr),
		.pos_x      (reg_q[gdcr_pkg::REG_POS_X]),
		.pos_y      (reg_q[gdcr_pkg::REG_POS_Y]),
		.dir_x      (reg_q[gdcr_pkg::REG_DIR_X]),
		.dir_y      (reg_q[gdcr_pkg::REG_DIR_Y]),
		.pln_x      (reg_q[gdcr_pkg::REG_PLANE_X]),
		.pln_y      (reg_q[gdcr_pkg::REG_PLANE_Y]),
		.ctrl       (ctrl),
		.stat       (stat),
		.res_valid  (result_valid),
		.res        (result)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> !busy && result_valid)
		else $error("result strobe without return to idle");
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_of_bounds |-> result.wall_color == 32'd0)
		else $error("out-of-map result carries a colour");
	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ctrl.load)
		else $error("cast loaded while busy");

endmodule
